### hdl/isps_pkg.sv
// Shared types, constants and the neighbor isolation test for the isolated S1 peak selector.
package isps_pkg;

	localparam int TIME_BITS   = 48;
	localparam int CHARGE_BITS = 24;
	localparam int INDEX_BITS  = 16;
	localparam int WIDTH_BITS  = 24;
	localparam int GAP_BITS    = 24;
	localparam int RATIO_BITS  = 4;
	localparam int SUM_BITS    = CHARGE_BITS + 1;
	localparam int PROD_BITS   = SUM_BITS + RATIO_BITS;
	localparam int CMP_BITS    = (TIME_BITS > GAP_BITS) ? TIME_BITS : GAP_BITS;
	localparam int CFG_BITS    = (GAP_BITS > RATIO_BITS) ? GAP_BITS : RATIO_BITS;

	localparam logic [GAP_BITS-1:0]   GAP_RESET   = GAP_BITS'(100);
	localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(3);
	localparam logic [INDEX_BITS-1:0] INDEX_MAX   = {INDEX_BITS{1'b1}};

	typedef logic [TIME_BITS-1:0]  time_t;
	typedef logic [SUM_BITS-1:0]   sum_t;
	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [GAP_BITS-1:0]   gap_t;
	typedef logic [RATIO_BITS-1:0] ratio_t;

	typedef enum logic {
		CFG_GAP_THRESHOLD = 1'b0,
		CFG_CHARGE_RATIO  = 1'b1
	} cfg_index_t;

	// One signal after the input register: end time and summed charge already formed.
	typedef struct packed {
		time_t start;
		time_t stop;
		sum_t  charge;
		logic  is_s1;
		logic  last;
	} item_t;

	typedef struct packed {
		logic   found;
		index_t index;
		sum_t   charge;
	} res_t;

	typedef struct packed {
		gap_t   gap_threshold;
		ratio_t charge_ratio;
	} cfg_t;

	// One side of a signal is isolated when the neighbor is absent, far enough
	// away, or small enough compared with the signal.
	function automatic logic side_isolated(logic present, time_t gap, gap_t thr,
			sum_t c, sum_t nb, ratio_t r);
		logic [PROD_BITS-1:0] lim;
		lim = PROD_BITS'(r) * PROD_BITS'(nb);
		return !present || (CMP_BITS'(gap) > CMP_BITS'(thr)) || (PROD_BITS'(c) > lim);
	endfunction

endpackage

### hdl/isps_cfg.sv
// Configuration registers of the isolated S1 peak selector.
module isps_cfg
	import isps_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  cfg_index_t          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	output cfg_t                cfg
);

	gap_t   gap_q;
	ratio_t ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q   <= GAP_RESET;
			ratio_q <= RATIO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAP_THRESHOLD: gap_q   <= cfg_data[GAP_BITS-1:0];
				CFG_CHARGE_RATIO:  ratio_q <= cfg_data[RATIO_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.gap_threshold = gap_q;
	assign cfg.charge_ratio  = ratio_q;

endmodule

### hdl/isps_in_stage.sv
// Input register: captures one item, forms end time and summed charge.
module isps_in_stage
	import isps_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [TIME_BITS-1:0]   start_time,
	input  logic [WIDTH_BITS-1:0]  width,
	input  logic [CHARGE_BITS-1:0] charge_top,
	input  logic [CHARGE_BITS-1:0] charge_bottom,
	input  logic                   is_s1,
	input  logic                   last_in_event,
	input  logic                   advance,
	output logic                   valid_s1,
	output item_t                  item_s1
);

	logic load;

	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load || advance) begin
			valid_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.start  <= start_time;
			item_s1.stop   <= start_time + TIME_BITS'(width);
			item_s1.charge <= SUM_BITS'(charge_top) + SUM_BITS'(charge_bottom);
			item_s1.is_s1  <= is_s1;
			item_s1.last   <= last_in_event;
		end
	end

endmodule

### hdl/isps_select.sv
// Event state: pending signal, previous neighbor, best candidate and signal count.
module isps_select
	import isps_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  advance,
	input  item_t item_s1,
	output logic  res_valid,
	output res_t  res
);

	time_t  prev_end_q;
	sum_t   prev_charge_q;
	logic   have_prev_q;
	time_t  pend_start_q;
	time_t  pend_end_q;
	sum_t   pend_charge_q;
	logic   pend_is_s1_q;
	logic   pend_valid_q;
	index_t pend_index_q;
	index_t count_q;
	sum_t   best_charge_q;
	index_t best_index_q;
	logic   best_found_q;

	logic   pend_wins;
	sum_t   best_charge_nx;
	index_t best_index_nx;
	logic   best_found_nx;
	logic   have_prev_nx;
	time_t  prev_end_nx;
	sum_t   prev_charge_nx;
	logic   new_wins;

	// Judge the pending signal with the new item as its right neighbor.
	always_comb begin
		pend_wins = pend_valid_q && pend_is_s1_q && (pend_charge_q > best_charge_q)
			&& side_isolated(have_prev_q, pend_start_q - prev_end_q, cfg.gap_threshold,
				pend_charge_q, prev_charge_q, cfg.charge_ratio)
			&& side_isolated(1'b1, item_s1.start - pend_end_q, cfg.gap_threshold,
				pend_charge_q, item_s1.charge, cfg.charge_ratio);
		best_charge_nx = pend_wins ? pend_charge_q : best_charge_q;
		best_index_nx  = pend_wins ? pend_index_q : best_index_q;
		best_found_nx  = pend_wins || best_found_q;
		have_prev_nx   = have_prev_q || pend_valid_q;
		prev_end_nx    = pend_valid_q ? pend_end_q : prev_end_q;
		prev_charge_nx = pend_valid_q ? pend_charge_q : prev_charge_q;
		// On the last item judge the new signal itself, with no right neighbor.
		new_wins = item_s1.is_s1 && (item_s1.charge > best_charge_nx)
			&& side_isolated(have_prev_nx, item_s1.start - prev_end_nx, cfg.gap_threshold,
				item_s1.charge, prev_charge_nx, cfg.charge_ratio);
	end

	always_comb begin
		res.found  = best_found_nx || new_wins;
		res.index  = new_wins ? count_q : (best_found_nx ? best_index_nx : '0);
		res.charge = new_wins ? item_s1.charge : (best_found_nx ? best_charge_nx : '0);
	end

	assign res_valid = advance && item_s1.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_end_q    <= '0;
			prev_charge_q <= '0;
			have_prev_q   <= 1'b0;
			pend_start_q  <= '0;
			pend_end_q    <= '0;
			pend_charge_q <= '0;
			pend_is_s1_q  <= 1'b0;
			pend_valid_q  <= 1'b0;
			pend_index_q  <= '0;
			count_q       <= '0;
			best_charge_q <= '0;
			best_index_q  <= '0;
			best_found_q  <= 1'b0;
		end else if (advance) begin
			if (item_s1.last) begin
				prev_end_q    <= '0;
				prev_charge_q <= '0;
				have_prev_q   <= 1'b0;
				pend_start_q  <= '0;
				pend_end_q    <= '0;
				pend_charge_q <= '0;
				pend_is_s1_q  <= 1'b0;
				pend_valid_q  <= 1'b0;
				pend_index_q  <= '0;
				count_q       <= '0;
				best_charge_q <= '0;
				best_index_q  <= '0;
				best_found_q  <= 1'b0;
			end else begin
				prev_end_q    <= prev_end_nx;
				prev_charge_q <= prev_charge_nx;
				have_prev_q   <= have_prev_nx;
				pend_start_q  <= item_s1.start;
				pend_end_q    <= item_s1.stop;
				pend_charge_q <= item_s1.charge;
				pend_is_s1_q  <= item_s1.is_s1;
				pend_valid_q  <= 1'b1;
				pend_index_q  <= count_q;
				if (count_q != INDEX_MAX) begin
					count_q <= count_q + 1'b1;
				end
				best_charge_q <= best_charge_nx;
				best_index_q  <= best_index_nx;
				best_found_q  <= best_found_nx;
			end
		end
	end

endmodule

### hdl/isolated_s1_peak_select_top.sv
// Top level of the isolated S1 peak selector: input stage, event logic, result register.
// Path: the last-in-event item of an event passes the input register, and its result
//   is then loaded into the result register.
// Throughput: one item per cycle; the input stalls only while a result waits
//   downstream and the input register holds another last-in-event item.
// Reset: arst_n clears all event state and valid flags at once and restores
//   gap_threshold to 100 and charge_ratio to 3; no clearing pass is needed.
module isolated_s1_peak_select_top
	import isps_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  cfg_index_t             cfg_index,
	input  logic [CFG_BITS-1:0]    cfg_data,
	// input item channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [TIME_BITS-1:0]   start_time,
	input  logic [WIDTH_BITS-1:0]  width,
	input  logic [CHARGE_BITS-1:0] charge_top,
	input  logic [CHARGE_BITS-1:0] charge_bottom,
	input  logic                   is_s1,
	input  logic                   last_in_event,
	// result item channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   found,
	output logic [INDEX_BITS-1:0]  best_index,
	output logic [SUM_BITS-1:0]    best_charge
);

	cfg_t  cfg;
	logic  valid_s1;
	item_t item_s1;
	logic  advance;
	logic  res_valid;
	res_t  res;
	logic  out_valid_q;
	res_t  out_q;

	isps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	isps_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.start_time    (start_time),
		.width         (width),
		.charge_top    (charge_top),
		.charge_bottom (charge_bottom),
		.is_s1         (is_s1),
		.last_in_event (last_in_event),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	// Advance the staged item unless it produces a result and the result
	// register is still held by the downstream side.
	assign advance = valid_s1 && (!item_s1.last || !out_valid_q || !out_stall);

	isps_select u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.advance   (advance),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register: load a fresh result, drop the flag once the item is taken,
	// hold everything while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = out_q.found;
	assign best_index  = out_q.index;
	assign best_charge = out_q.charge;

endmodule

### hdl/isps_checker.sv
// Port-level checks of the isolated S1 peak selector and their binding to the top level.
module isps_checker
	import isps_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic                   found,
	input logic [INDEX_BITS-1:0]  best_index,
	input logic [SUM_BITS-1:0]    best_charge
);

	// A held result stays shown.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A held result keeps its fields.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(found) && $stable(best_index)
			&& $stable(best_charge))
		else $error("result changed while stalled");

	// With no result waiting the input never stalls.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	// An empty result carries zero fields.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> best_index == '0 && best_charge == '0)
		else $error("empty result with nonzero fields");

	// A chosen signal beat a best charge of zero.
	a_found_charge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> best_charge != '0)
		else $error("found result with zero charge");

endmodule

bind isolated_s1_peak_select_top isps_checker u_isps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.found       (found),
	.best_index  (best_index),
	.best_charge (best_charge)
);
